FILE: sv/motor_feedback_encoder_unwrap_unit_assert.svh
// assertion macros shared by the encoder unwrap rtl
`ifndef MOTOR_FEEDBACK_ENCODER_UNWRAP_UNIT_ASSERT_SVH
`define MOTOR_FEEDBACK_ENCODER_UNWRAP_UNIT_ASSERT_SVH

// clocked check, switched off while reset is held
`define MFEU_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check with no reset qualifier
`define MFEU_ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/mfeu_pkg.sv
// shared types, constants and helpers of the encoder unwrap block
`default_nettype none

package mfeu_pkg;

  localparam int unsigned RES_W      = 17;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned READING_W  = 16;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned POS_W      = 32;

  localparam logic [RES_W-1:0] RES_RESET = 17'd8192;

  // register index taken from paddr[2]
  localparam logic REG_RESOLUTION = 1'b0;

  localparam logic signed [POS_W-1:0] POS_SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [POS_W-1:0] POS_SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [POS_W-1:0] position_total;
    logic signed [POS_W-1:0] turn_count;
  } unwrap_status_t;

  function automatic logic signed [POS_W-1:0] saturate32(input logic [ACC_W-1:0] acc);
    logic fits;
    begin
      // fits when bits 63:31 all agree
      fits = (&acc[ACC_W-1:POS_W-1]) | ~(|acc[ACC_W-1:POS_W-1]);
      if (fits) begin
        saturate32 = signed'(acc[POS_W-1:0]);
      end else if (acc[ACC_W-1]) begin
        saturate32 = POS_SAT_MIN;
      end else begin
        saturate32 = POS_SAT_MAX;
      end
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/mfeu_cfg.sv
// apb register holding the encoder resolution
`default_nettype none

module mfeu_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mfeu_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mfeu_pkg::DATA_W-1:0]   pwdata,
  output logic      [mfeu_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output logic      [mfeu_pkg::RES_W-1:0]    resolution
);

  logic [mfeu_pkg::RES_W-1:0] resolution_r;
  logic [mfeu_pkg::RES_W-1:0] resolution_nxt;
  logic                       hit_res;

  assign hit_res = (paddr[2] == mfeu_pkg::REG_RESOLUTION);

  always_comb begin
    resolution_nxt = resolution_r;
    if (psel && penable && pwrite && hit_res) begin
      resolution_nxt = pwdata[mfeu_pkg::RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resolution_r <= mfeu_pkg::RES_RESET;
    end else begin
      resolution_r <= resolution_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (hit_res) begin
      prdata = {{(mfeu_pkg::DATA_W-mfeu_pkg::RES_W){1'b0}}, resolution_r};
    end
  end

  assign pready     = 1'b1;
  assign resolution = resolution_r;

endmodule

`default_nettype wire

FILE: sv/mfeu_unwrap.sv
// multiturn state: previous reading, position accumulator and turn counter
`default_nettype none

`include "motor_feedback_encoder_unwrap_unit_assert.svh"

module mfeu_unwrap (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             load,
  input  wire logic [mfeu_pkg::READING_W-1:0]   reading,
  input  wire logic [mfeu_pkg::RES_W-1:0]       resolution,
  output mfeu_pkg::unwrap_status_t              status
);

  logic                                seen_r;
  logic                                seen_nxt;
  logic [mfeu_pkg::READING_W-1:0]      prev_r;
  logic [mfeu_pkg::READING_W-1:0]      prev_nxt;
  logic [mfeu_pkg::ACC_W-1:0]          acc_r;
  logic [mfeu_pkg::ACC_W-1:0]          acc_nxt;
  logic [mfeu_pkg::POS_W-1:0]          wrap_r;
  logic [mfeu_pkg::POS_W-1:0]          wrap_nxt;

  logic signed [18:0] delta;
  logic signed [18:0] half;
  logic signed [18:0] res_s;
  logic signed [18:0] delta_adj;
  logic               over;
  logic               under;

  assign delta = signed'({3'b000, reading}) - signed'({3'b000, prev_r});
  assign res_s = signed'({2'b00, resolution});
  assign half  = signed'({3'b000, resolution[mfeu_pkg::RES_W-1:1]});
  assign over  = delta > half;
  assign under = delta < -half;

  always_comb begin
    delta_adj = delta;
    if (over) begin
      delta_adj = delta - res_s;
    end else if (under) begin
      delta_adj = delta + res_s;
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    prev_nxt = prev_r;
    acc_nxt  = acc_r;
    wrap_nxt = wrap_r;
    if (load) begin
      seen_nxt = 1'b1;
      prev_nxt = reading;
      if (!seen_r) begin
        acc_nxt = {{(mfeu_pkg::ACC_W-mfeu_pkg::READING_W){1'b0}}, reading};
      end else begin
        acc_nxt = acc_r + {{(mfeu_pkg::ACC_W-19){delta_adj[18]}}, delta_adj};
        if (over) begin
          wrap_nxt = wrap_r - 32'd1;
        end else if (under) begin
          wrap_nxt = wrap_r + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      prev_r <= '0;
      acc_r  <= '0;
      wrap_r <= '0;
    end else begin
      seen_r <= seen_nxt;
      prev_r <= prev_nxt;
      acc_r  <= acc_nxt;
      wrap_r <= wrap_nxt;
    end
  end

  assign status.position_total = mfeu_pkg::saturate32(acc_r);
  assign status.turn_count     = signed'(wrap_r);

  `MFEU_ASSERT_RST(a_first_loads_raw, clk, rst_n, load && !seen_r |=> acc_r == {48'd0, $past(reading)}, "first word did not load the accumulator")
  `MFEU_ASSERT_RST(a_turn_step_one, clk, rst_n, load |=> wrap_r == $past(wrap_r) || wrap_r == $past(wrap_r) + 32'd1 || wrap_r == $past(wrap_r) - 32'd1, "turn counter moved by more than one")
  `MFEU_ASSERT_RST(a_state_holds, clk, rst_n, !load |=> $stable(acc_r) && $stable(wrap_r) && $stable(prev_r), "unwrap state changed with no word")

endmodule

`default_nettype wire

FILE: sv/motor_feedback_encoder_unwrap_unit.sv
// Multiturn encoder unwrap for 8-byte motor feedback words. One word is accepted per clock
// cycle while in_stall is low; each word passes through the input register and then the
// output register, and throughput is one word per cycle while out_stall is low, with a
// single unwrap pass (19-bit delta, compare against half the resolution, 64-bit
// accumulate). A stalled result holds the input register, and in_stall is raised only
// while both registers are occupied. 16-bit fields are big-endian (byte 0 is the high
// byte of the reading). The first word after reset loads the accumulator with the raw
// reading; position_total is the accumulator saturated to 32 bits, turn_count wraps.
// encoder_resolution sits at byte address 0 of the apb port; the user must write it only
// while no word is in flight, and the block itself does not enforce this.
`default_nettype none

`include "motor_feedback_encoder_unwrap_unit_assert.svh"

module motor_feedback_encoder_unwrap_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [63:0]                     in_frame_bytes,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [15:0]                          out_encoder_raw,
  output logic signed [15:0]                   out_speed_rpm,
  output logic signed [15:0]                   out_current_raw,
  output logic [7:0]                           out_temperature,
  output logic [7:0]                           out_spare_byte,
  output logic signed [31:0]                   out_position_total,
  output logic signed [31:0]                   out_turn_count,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mfeu_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [mfeu_pkg::DATA_W-1:0]     pwdata,
  output logic      [mfeu_pkg::DATA_W-1:0]     prdata,
  output logic                                 pready
);

  logic                          in_valid_r;
  logic                          in_valid_nxt;
  logic [63:0]                   frame_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [63:0]                   out_frame_r;
  logic                          advance;
  logic                          move;
  logic                          in_acc;
  logic [mfeu_pkg::RES_W-1:0]    resolution;
  mfeu_pkg::unwrap_status_t      status;

  mfeu_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .resolution (resolution)
  );

  // output register free or being drained this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign move     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  assign in_valid_nxt  = in_acc || (in_valid_r && !advance);
  assign out_valid_nxt = move || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      frame_r <= in_frame_bytes;
    end
    if (move) begin
      out_frame_r <= frame_r;
    end
  end

  // unwrap state steps together with the output register load
  mfeu_unwrap u_unwrap (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (move),
    .reading    ({frame_r[7:0], frame_r[15:8]}),
    .resolution (resolution),
    .status     (status)
  );

  assign out_valid          = out_valid_r;
  assign out_encoder_raw    = {out_frame_r[7:0], out_frame_r[15:8]};
  assign out_speed_rpm      = signed'({out_frame_r[23:16], out_frame_r[31:24]});
  assign out_current_raw    = signed'({out_frame_r[39:32], out_frame_r[47:40]});
  assign out_temperature    = out_frame_r[55:48];
  assign out_spare_byte     = out_frame_r[63:56];
  assign out_position_total = status.position_total;
  assign out_turn_count     = status.turn_count;

  `MFEU_ASSERT_RST(a_stall_when_blocked, clk, rst_n, in_valid_r && out_valid_r && out_stall |-> in_stall, "input not stalled behind a full output")
  `MFEU_ASSERT_RST(a_no_stall_when_empty, clk, rst_n, !in_valid_r |-> !in_stall, "stall raised with an empty input register")
  `MFEU_ASSERT_RST(a_out_from_input, clk, rst_n, $rose(out_valid_r) |-> $past(in_valid_r), "result appeared with no word in the input register")

endmodule

`default_nettype wire

FILE: tb/tb_motor_feedback_encoder_unwrap_unit.sv
// self-checking testbench for the multiturn encoder unwrap block
`timescale 1ns / 100ps

module tb_motor_feedback_encoder_unwrap_unit;

  localparam logic [mfeu_pkg::ADDR_W-1:0] ADDR_RESOLUTION =
    {mfeu_pkg::REG_RESOLUTION, 2'b00};
  localparam logic [mfeu_pkg::ADDR_W-1:0] ADDR_UNMAPPED   =
    {~mfeu_pkg::REG_RESOLUTION, 2'b00};
  localparam int RANDOM_SEGMENTS  = 8;
  localparam int SEGMENT_WORDS    = 150;
  // half of this is 65533, so full-span hops unwrap into near full steps one way
  localparam int DRIVE_RESOLUTION = 131066;
  localparam int CLIMB_ROUNDS     = 40;
  localparam int FALL_ROUNDS      = 40;
  localparam int LIMIT_CYCLES     = 200_000;

  typedef struct packed {
    logic [15:0]        encoder_raw;
    logic signed [15:0] speed_rpm;
    logic signed [15:0] current_raw;
    logic [7:0]         temperature;
    logic [7:0]         spare_byte;
    logic signed [31:0] position_total;
    logic signed [31:0] turn_count;
  } feedback_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] in_frame_bytes = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_encoder_raw;
  logic signed [15:0] out_speed_rpm;
  logic signed [15:0] out_current_raw;
  logic [7:0] out_temperature;
  logic [7:0] out_spare_byte;
  logic signed [31:0] out_position_total;
  logic signed [31:0] out_turn_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mfeu_pkg::ADDR_W-1:0] paddr = '0;
  logic [mfeu_pkg::DATA_W-1:0] pwdata = '0;
  logic [mfeu_pkg::DATA_W-1:0] prdata;
  logic pready;

  motor_feedback_encoder_unwrap_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_frame_bytes(in_frame_bytes),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_encoder_raw(out_encoder_raw), .out_speed_rpm(out_speed_rpm),
    .out_current_raw(out_current_raw), .out_temperature(out_temperature),
    .out_spare_byte(out_spare_byte), .out_position_total(out_position_total),
    .out_turn_count(out_turn_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // frames waiting to be sent and results waiting to arrive
  logic [63:0] pending_frames[$];
  feedback_t   expected_feedback[$];

  // predicted block state
  logic [mfeu_pkg::RES_W-1:0] res_m = mfeu_pkg::RES_RESET;
  logic             seen_first_m = 1'b0;
  logic [15:0]      prev_m = '0;
  logic [63:0]      pos_acc_m = '0;
  logic [31:0]      turns_m = '0;

  int error_count = 0;
  int word_count = 0;
  int cycle_count = 0;
  logic in_fire = 1'b0;

  // stimulus generator view of the block
  int gen_res = int'(mfeu_pkg::RES_RESET);
  int gen_last = 0;

  function automatic logic [63:0] make_frame(logic [15:0] reading, logic [15:0] speed,
                                             logic [15:0] current, logic [7:0] temp,
                                             logic [7:0] spare);
    return {spare, temp, current[7:0], current[15:8], speed[7:0], speed[15:8],
            reading[7:0], reading[15:8]};
  endfunction

  function automatic feedback_t decode_and_unwrap(logic [63:0] frame);
    feedback_t f;
    logic [15:0] reading;
    int delta;
    int half;
    longint acc_s;
    reading = {frame[7:0], frame[15:8]};
    if (!seen_first_m) begin
      pos_acc_m = {48'b0, reading};
      seen_first_m = 1'b1;
    end else begin
      half = int'(res_m) / 2;
      delta = int'(reading) - int'(prev_m);
      if (delta > half) begin
        delta = delta - int'(res_m);
        turns_m = turns_m - 32'd1;
      end else if (delta < -half) begin
        delta = delta + int'(res_m);
        turns_m = turns_m + 32'd1;
      end
      pos_acc_m = pos_acc_m + 64'(longint'(delta));
    end
    prev_m = reading;
    acc_s = signed'(pos_acc_m);
    f.encoder_raw = reading;
    f.speed_rpm = {frame[23:16], frame[31:24]};
    f.current_raw = {frame[39:32], frame[47:40]};
    f.temperature = frame[55:48];
    f.spare_byte = frame[63:56];
    if (acc_s > longint'(mfeu_pkg::POS_SAT_MAX)) begin
      f.position_total = mfeu_pkg::POS_SAT_MAX;
    end else if (acc_s < longint'(mfeu_pkg::POS_SAT_MIN)) begin
      f.position_total = mfeu_pkg::POS_SAT_MIN;
    end else begin
      f.position_total = acc_s[31:0];
    end
    f.turn_count = turns_m;
    return f;
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      flag_error($sformatf("word %0d %s: expected %h, got %h", word_count, name,
                           exp_val, act_val));
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("motor_feedback_encoder_unwrap_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
  end

  // monitor: tracks config writes, predicts on accepted frames, checks results
  always @(posedge clk) begin
    feedback_t exp_f;
    if (!rst_n) begin
      res_m = mfeu_pkg::RES_RESET;
      seen_first_m = 1'b0;
      prev_m = '0;
      pos_acc_m = '0;
      turns_m = '0;
    end else begin
      if (psel && penable && pready && pwrite && paddr == ADDR_RESOLUTION) begin
        res_m = pwdata[mfeu_pkg::RES_W-1:0];
      end
      if (psel && penable && pready && !pwrite && paddr == ADDR_RESOLUTION) begin
        check_field("resolution readback",
                    {{(mfeu_pkg::DATA_W-mfeu_pkg::RES_W){1'b0}}, res_m}, prdata);
      end
      if (in_valid && !in_stall) begin
        expected_feedback.push_back(decode_and_unwrap(in_frame_bytes));
      end
      if (out_valid && !out_stall) begin
        if (expected_feedback.size() == 0) begin
          flag_error($sformatf("word %0d arrived with nothing expected", word_count));
        end else begin
          exp_f = expected_feedback.pop_front();
          check_field("encoder_raw", exp_f.encoder_raw, out_encoder_raw);
          check_field("speed_rpm", exp_f.speed_rpm, out_speed_rpm);
          check_field("current_raw", exp_f.current_raw, out_current_raw);
          check_field("temperature", exp_f.temperature, out_temperature);
          check_field("spare_byte", exp_f.spare_byte, out_spare_byte);
          check_field("position_total", exp_f.position_total, out_position_total);
          check_field("turn_count", exp_f.turn_count, out_turn_count);
        end
        word_count++;
      end
    end
  end

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid || in_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_frames.size() != 0) begin
        in_valid <= 1'b1;
        in_frame_bytes <= pending_frames.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between free, light, heavy and periodic modes
  rx_mode_t rx_mode = RX_FREE;
  int rx_left = 0;
  int rx_phase = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(3));
        rx_left = $urandom_range(64, 512);
      end else begin
        rx_left--;
      end
      rx_phase = (rx_phase + 1) % 7;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(1) == 0);
        default:  out_stall <= (rx_phase < 3);
      endcase
    end
  end

  task automatic wait_idle();
    while (pending_frames.size() != 0 || in_valid || expected_feedback.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(bit is_write, logic [mfeu_pkg::ADDR_W-1:0] addr,
                            logic [mfeu_pkg::DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_resolution(logic [mfeu_pkg::DATA_W-1:0] value);
    wait_idle();
    cfg_access(1'b1, ADDR_RESOLUTION, value);
    cfg_access(1'b0, ADDR_RESOLUTION, '0);
    gen_res = int'(value[mfeu_pkg::RES_W-1:0]);
  endtask

  task automatic queue_word(logic [15:0] reading, logic [15:0] speed, logic [15:0] current,
                            logic [7:0] temp, logic [7:0] spare);
    pending_frames.push_back(make_frame(reading, speed, current, temp, spare));
    gen_last = int'(reading);
  endtask

  task automatic queue_reading(logic [15:0] reading);
    queue_word(reading, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // mostly plausible motion, some hops right at the unwrap threshold, some noise
  function automatic logic [15:0] next_reading(int last, int res);
    int half;
    int step;
    int pick;
    half = res / 2;
    pick = $urandom_range(9);
    if (pick < 2) begin
      return 16'($urandom);
    end
    if (pick < 4) begin
      case ($urandom_range(3))
        0:       step = half;
        1:       step = half + 1;
        2:       step = -half;
        default: step = -half - 1;
      endcase
      return 16'(last + step);
    end
    if (res >= 2 && res <= 65536) begin
      if (last >= res) begin
        return 16'($urandom_range(0, res - 1));
      end
      step = int'($urandom_range(0, 2 * half)) - half;
      return 16'(((last + step) % res + res) % res);
    end
    return 16'(last + int'($urandom_range(0, 4000)) - 2000);
  endfunction

  task automatic queue_sweep(int rounds, bit falling);
    logic [15:0] r;
    for (int n = 0; n < rounds * 5; n++) begin
      case (n % 5)
        0:       r = 16'hffff;
        1:       r = 16'h0001;
        2:       r = 16'hfffe;
        3:       r = 16'h0000;
        default: r = 16'hfffd;
      endcase
      queue_reading(falling ? ~r : r);
    end
  endtask

  initial begin
    int seg_res;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default resolution: first frame, threshold edges, full wraps
    queue_word(16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff);
    queue_word(16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    queue_word(16'h1000, 16'h7fff, 16'h8000, 8'h80, 8'h7f);
    queue_word(16'h0000, 16'h8000, 16'h7fff, 8'h01, 8'hfe);
    queue_word(16'h1001, 16'h0001, 16'hfffe, 8'h7f, 8'h80);
    queue_word(16'h0000, 16'hfffe, 16'h0001, 8'hfe, 8'h01);
    queue_word(16'h1fff, 16'h1234, 16'h5678, 8'h9a, 8'hbc);
    queue_word(16'h0000, 16'h5678, 16'h1234, 8'hbc, 8'h9a);
    queue_word(16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
    queue_word(16'ha5a5, 16'h5a5a, 16'ha5a5, 8'h5a, 8'ha5);

    // zero resolution: every nonzero step counts a turn
    set_resolution(32'd0);
    queue_reading(16'h0010);
    queue_reading(16'h0010);
    queue_reading(16'h0011);

    set_resolution(32'd1);
    queue_reading(16'h0011);
    queue_reading(16'h0012);
    queue_reading(16'h0010);

    // upper bits beyond the register are dropped
    set_resolution(32'hfffe_0002);
    queue_reading(16'h0012);
    queue_reading(16'h0011);

    set_resolution(32'd65536);
    queue_reading(16'hffff);
    queue_reading(16'h0000);
    queue_reading(16'h8000);
    queue_reading(16'h0000);

    // widest resolution, then a write past the register list that must not land
    set_resolution(32'h0001_ffff);
    cfg_access(1'b1, ADDR_UNMAPPED, 32'd3);
    queue_reading(16'hffff);
    queue_reading(16'h0000);

    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      case (seg)
        0:       seg_res = 8192;
        1:       seg_res = 65536;
        2:       seg_res = 4096;
        3:       seg_res = 16384;
        4:       seg_res = 1000;
        5:       seg_res = $urandom_range(2, 65536);
        6:       seg_res = $urandom_range(0, 131071);
        default: seg_res = 3;
      endcase
      set_resolution(32'(seg_res));
      for (int k = 0; k < SEGMENT_WORDS; k++) begin
        queue_reading(next_reading(gen_last, gen_res));
      end
    end

    // one-way runs with the widest unwrap steps in each direction
    set_resolution(32'(DRIVE_RESOLUTION));
    queue_sweep(CLIMB_ROUNDS, 1'b0);
    queue_sweep(FALL_ROUNDS, 1'b1);

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("motor_feedback_encoder_unwrap_unit: match");
    end else begin
      $display("motor_feedback_encoder_unwrap_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/mfeu_pkg.sv
sv/mfeu_cfg.sv
sv/mfeu_unwrap.sv
sv/motor_feedback_encoder_unwrap_unit.sv
tb/tb_motor_feedback_encoder_unwrap_unit.sv
